FILE: rtl/core/ftab_pkg.sv
// Package for the flow table with aging: widths, codes and reset values.
// Used by every module in rtl/core; depends on nothing.
package ftab_pkg;

  localparam int unsigned TableEntriesDef = 32;
  localparam int unsigned KeyW            = 64;
  localparam int unsigned StampW          = 32;
  localparam int unsigned CfgW            = 16;
  localparam int unsigned CountW          = 6;

  localparam logic [CfgW-1:0] ExpireAfterRst   = 16'd30;
  localparam logic [CfgW-1:0] CleanupPeriodRst = 16'd10;

  localparam logic       CfgExpireAfter   = 1'b0;
  localparam logic       CfgCleanupPeriod = 1'b1;

  localparam logic       FuncPacket = 1'b0;
  localparam logic       FuncTick   = 1'b1;

  localparam logic [1:0] KindStatus  = 2'd0;
  localparam logic [1:0] KindListing = 2'd1;
  localparam logic [1:0] KindSummary = 2'd2;

  localparam logic [1:0] StatusHit      = 2'd0;
  localparam logic [1:0] StatusInserted = 2'd1;
  localparam logic [1:0] StatusFull     = 2'd2;

  // Command from the controller to every cell of the row.
  typedef struct packed {
    logic              write;   // write the key and stamp below
    logic              refresh; // refresh stamp only
    logic [KeyW-1:0]   key;
    logic [StampW-1:0] stamp;
    logic              sweep;   // cell checks its own age this cycle
    logic [StampW-1:0] now;
    logic [CfgW-1:0]   expire;
  } cell_cmd_t;

endpackage

FILE: rtl/core/ftab_cell.sv
// One slot of the flow table: valid bit, key, stamp and the local compare.
// Depends on ftab_pkg.
module ftab_cell import ftab_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cell_cmd_t         cmd_i,
  input  logic              sel_i,    // this cell is the target of write/refresh
  input  logic [KeyW-1:0]   probe_i,
  output logic              valid_o,
  output logic              match_o,
  output logic [KeyW-1:0]   key_o,
  output logic [StampW-1:0] stamp_o
);

  logic              valid_q;
  logic [KeyW-1:0]   key_q;
  logic [StampW-1:0] stamp_q;
  logic [StampW-1:0] age;

  assign age = cmd_i.now - stamp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (sel_i && cmd_i.write) begin
      valid_q <= 1'b1;
    end else if (cmd_i.sweep && valid_q && (age > {16'd0, cmd_i.expire})) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sel_i && cmd_i.write) begin
      key_q <= cmd_i.key;
    end
    if (sel_i && (cmd_i.write || cmd_i.refresh)) begin
      stamp_q <= cmd_i.stamp;
    end
  end

  assign valid_o = valid_q;
  assign match_o = valid_q && (key_q == probe_i);
  assign key_o   = key_q;
  assign stamp_o = stamp_q;

endmodule

FILE: rtl/core/flow_table_with_aging.sv
// Top level of the flow table with aging: stream ports, controller and the row
// of ftab_cell slots. Depends on ftab_pkg and ftab_cell.
//
// The block learns senders keyed by source address, source port and
// destination port into a row of TABLE_ENTRIES cells. For a packet request
// the accepting edge registers the key. In the next cycle the key is compared
// against all cells in parallel, the hit or the lowest free cell is updated,
// and the single status result is loaded into the output register. A tick
// request only advances the stamp unless it starts a sweep. A sweep then
// visits the cells one per cycle, its pace set by the single output register,
// stalling whenever the downstream side holds tready low. Listings of the
// surviving cells come out in slot order, followed by a summary with the
// survivor count. Configuration writes are taken on any cycle and should
// only be issued while the block is idle.
module flow_table_with_aging import ftab_pkg::*; #(
  parameter int unsigned TABLE_ENTRIES = TableEntriesDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [63:0]  s_axis_tdata,  // source_address, source_port, target_port
  input  logic         s_axis_tuser,  // func
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [103:0] m_axis_tdata,  // status, entry_address, entry_source_port,
                                      // entry_target_port, entry_stamp,
                                      // live_count
  output logic [1:0]   m_axis_tuser,  // kind
  output logic         m_axis_tlast,  // final_res
  input  logic         cfg_we_i,
  input  logic         cfg_idx_i,
  input  logic [CfgW-1:0] cfg_data_i
);

  localparam int unsigned IdxW = $clog2(TABLE_ENTRIES);

  typedef enum logic [1:0] {St_Idle, St_Lookup, St_Sweep, St_Summary} state_e;

  state_e               state_q;
  logic [CfgW-1:0]      expire_q, period_q;
  logic [StampW-1:0]    now_q;
  logic [CfgW-1:0]      ticks_q;
  logic [KeyW-1:0]      key_q;
  logic [IdxW:0]        ptr_q;
  logic [CountW-1:0]    live_q;

  logic                 out_v_q;
  logic [1:0]           out_kind_q, out_status_q;
  logic [KeyW-1:0]      out_key_q;
  logic [StampW-1:0]    out_stamp_q;
  logic [CountW-1:0]    out_live_q;
  logic                 out_last_q;

  cell_cmd_t                          cmd;
  logic [TABLE_ENTRIES-1:0]           sel, valid, match;
  logic [KeyW-1:0]                    ckey   [TABLE_ENTRIES];
  logic [StampW-1:0]                  cstamp [TABLE_ENTRIES];
  logic [IdxW-1:0]                    hit_idx, free_idx, ptr_idx;
  logic                               hit_any, free_any, out_free, cur_alive;
  logic                               out_load;
  logic [StampW-1:0]                  cur_age;
  logic [CfgW-1:0]                    ticks_inc, period_eff;

  assign ptr_idx  = ptr_q[IdxW-1:0];
  assign out_free = !out_v_q || m_axis_tready;
  assign s_axis_tready = (state_q == St_Idle) && out_free;

  // Priority pick of the lowest hit and the lowest free cell.
  always_comb begin
    hit_idx = '0; free_idx = '0; hit_any = 1'b0; free_any = 1'b0;
    for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
      if (match[i]) begin
        hit_idx = IdxW'(i); hit_any = 1'b1;
      end
      if (!valid[i]) begin
        free_idx = IdxW'(i); free_any = 1'b1;
      end
    end
  end

  assign cur_age   = now_q - cstamp[ptr_idx];
  assign cur_alive = valid[ptr_idx] && (cur_age <= {16'd0, expire_q});

  // A new result request enters the output register in this cycle.
  assign out_load = out_free && ((state_q == St_Lookup) || (state_q == St_Summary) ||
                                 ((state_q == St_Sweep) && cur_alive));

  always_comb begin
    cmd         = '0;
    sel         = '0;
    cmd.key     = key_q;
    cmd.stamp   = now_q;
    cmd.now     = now_q;
    cmd.expire  = expire_q;
    if (state_q == St_Lookup && out_free) begin
      if (hit_any) begin
        cmd.refresh = 1'b1; sel[hit_idx] = 1'b1;
      end else if (free_any) begin
        cmd.write = 1'b1; sel[free_idx] = 1'b1;
      end
    end
    if (state_q == St_Sweep && out_free) begin
      cmd.sweep = 1'b1;
    end
  end

  for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
    logic sweep_here;
    cell_cmd_t ccmd;
    assign sweep_here = cmd.sweep && (ptr_idx == IdxW'(g));
    always_comb begin
      ccmd       = cmd;
      ccmd.sweep = sweep_here;
    end
    ftab_cell u_cell (
      .clk_i, .rst_ni, .cmd_i(ccmd), .sel_i(sel[g]), .probe_i(key_q),
      .valid_o(valid[g]), .match_o(match[g]), .key_o(ckey[g]), .stamp_o(cstamp[g])
    );
  end

  assign ticks_inc  = ticks_q + CfgW'(1);
  assign period_eff = (period_q == '0) ? CfgW'(1) : period_q;

  // Controller state and the output register with its payload.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= St_Idle;
      expire_q     <= ExpireAfterRst;
      period_q     <= CleanupPeriodRst;
      now_q        <= '0;
      ticks_q      <= '0;
      key_q        <= '0;
      out_v_q      <= 1'b0;
      ptr_q        <= '0;
      live_q       <= '0;
      out_kind_q   <= KindStatus;
      out_status_q <= StatusHit;
      out_key_q    <= '0;
      out_stamp_q  <= '0;
      out_live_q   <= '0;
      out_last_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CfgExpireAfter) expire_q <= cfg_data_i;
        else                             period_q <= cfg_data_i;
      end
      out_v_q <= out_load || (out_v_q && !m_axis_tready);
      unique case (state_q)
        St_Idle: begin
          if (s_axis_tvalid && s_axis_tready) begin
            if (s_axis_tuser == FuncPacket) begin
              key_q   <= {s_axis_tdata[31:0], s_axis_tdata[47:32], s_axis_tdata[63:48]};
              state_q <= St_Lookup;
            end else begin
              now_q <= now_q + StampW'(1);
              if (ticks_inc < period_eff) begin
                ticks_q <= ticks_inc;
              end else begin
                ticks_q <= '0;
                ptr_q   <= '0;
                live_q  <= '0;
                state_q <= St_Sweep;
              end
            end
          end
        end
        St_Lookup: begin
          if (out_free) begin
            out_kind_q   <= KindStatus;
            out_key_q    <= key_q;
            out_live_q   <= '0;
            out_last_q   <= 1'b1;
            out_status_q <= hit_any ? StatusHit : (free_any ? StatusInserted : StatusFull);
            out_stamp_q  <= (hit_any || free_any) ? now_q : '0;
            state_q      <= St_Idle;
          end
        end
        St_Sweep: begin
          if (out_free) begin
            out_kind_q   <= KindListing;
            out_status_q <= StatusHit;
            out_key_q    <= ckey[ptr_idx];
            out_stamp_q  <= cstamp[ptr_idx];
            out_live_q   <= '0;
            out_last_q   <= 1'b0;
            if (cur_alive) begin
              live_q <= live_q + CountW'(1);
            end
            if (ptr_q == (IdxW+1)'(TABLE_ENTRIES - 1)) state_q <= St_Summary;
            ptr_q <= ptr_q + (IdxW+1)'(1);
          end
        end
        St_Summary: begin
          if (out_free) begin
            out_kind_q   <= KindSummary;
            out_status_q <= StatusHit;
            out_key_q    <= '0;
            out_stamp_q  <= '0;
            out_live_q   <= live_q;
            out_last_q   <= 1'b1;
            state_q      <= St_Idle;
          end
        end
        default: state_q <= St_Idle;
      endcase
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tuser  = out_kind_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = {out_live_q, out_stamp_q, out_key_q[15:0],
                          out_key_q[31:16], out_key_q[63:32], out_status_q};

  // A summary always closes its sweep.
  a_sum_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && out_kind_q == KindSummary) |-> out_last_q) else $error("summary not last");
  // No input is taken while a sweep walks the cells.
  a_no_take_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == St_Sweep) |-> !s_axis_tready) else $error("input taken in sweep");
  // Survivor count never exceeds the table size.
  a_live_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    live_q <= CountW'(TABLE_ENTRIES)) else $error("live count overflow");

endmodule
